>>> src/cbm_pkg.sv
// Shared types, register codes and helpers for the cartridge bank mapper.
`default_nettype none

package cbm_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_WRITE     = 2'd1,
        ACT_PRG_XLATE = 2'd2,
        ACT_PAT_XLATE = 2'd3
    } action_t;

    // Mapper register numbers (low four write address bits)
    localparam logic [3:0] REG_PAT_FIRST = 4'd0;
    localparam logic [3:0] REG_PAT_LAST  = 4'd7;
    localparam logic [3:0] REG_PRG_BANK  = 4'd8;
    localparam logic [3:0] REG_MIRROR    = 4'd9;
    localparam logic [3:0] REG_IRQ_CTRL  = 4'd10;
    localparam logic [3:0] REG_CNT_LO    = 4'd11;
    localparam logic [3:0] REG_CNT_HI    = 4'd12;

    // Configuration register numbers
    localparam logic CFG_AND_MASK = 1'b0;
    localparam logic CFG_OR_BITS  = 1'b1;

    localparam logic [7:0] BANK_MASK_RESET = 8'hFF;
    localparam logic [7:0] BANK_OR_RESET   = 8'h00;
    localparam logic [7:0] FIXED_PRG_BANK  = 8'hFF;

    typedef struct packed {
        action_t     action;
        logic [3:0]  reg_index;
        logic [7:0]  write_value;
        logic [14:0] cpu_offset;
        logic [12:0] ppu_offset;
    } item_t;

    typedef struct packed {
        logic        irq_line;
        logic [21:0] mapped_addr;
        logic [1:0]  mirror_mode;
    } result_t;

    typedef struct packed {
        logic [7:0] and_mask;
        logic [7:0] or_bits;
    } bank_cfg_t;

    // Mask a bank number, then force the configured bits on
    function automatic logic [7:0] map_bank(input logic [7:0] bank, input bank_cfg_t cfg);
        map_bank = (bank & cfg.and_mask) | cfg.or_bits;
    endfunction

endpackage

`default_nettype wire

>>> src/cbm_apb_regs.sv
// APB configuration registers: bank mask and forced bank bits.
`default_nettype none

module cbm_apb_regs
    import cbm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output bank_cfg_t        cfg
);

    logic [7:0] and_mask_reg;
    logic [7:0] or_bits_reg;
    logic       wr_en;
    logic       cfg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign cfg_sel = paddr[2];

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            and_mask_reg <= BANK_MASK_RESET;
            or_bits_reg  <= BANK_OR_RESET;
        end else if (wr_en) begin
            if (cfg_sel == CFG_AND_MASK) begin
                and_mask_reg <= pwdata[7:0];
            end else begin
                or_bits_reg <= pwdata[7:0];
            end
        end
    end

    // Read back the selected register
    always_comb begin
        prdata = '0;
        if (cfg_sel == CFG_AND_MASK) begin
            prdata[7:0] = and_mask_reg;
        end else begin
            prdata[7:0] = or_bits_reg;
        end
    end

    assign cfg.and_mask = and_mask_reg;
    assign cfg.or_bits  = or_bits_reg;

    // Unused low address bits select nothing
    logic unused_addr;
    assign unused_addr = ^paddr[1:0] ^ ^pwdata[31:8];

endmodule

`default_nettype wire

>>> src/cbm_in_stage.sv
// Input register stage: holds one request until the engine takes it.
`default_nettype none

module cbm_in_stage
    import cbm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  item_t     in_item,
    output logic      held_valid,
    input  wire logic held_take,
    output item_t     held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || held_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !held_take);

    // Track occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

>>> src/cbm_engine.sv
// Mapper state, register decode, interrupt counter and address translation.
`default_nettype none

module cbm_engine
    import cbm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic fire,
    input  item_t     item,
    input  bank_cfg_t cfg,
    output result_t   result
);

    logic [7:0]  pat_bank_reg [8];
    logic [7:0]  pat_bank_next [8];
    logic [7:0]  prg_bank_reg;
    logic [7:0]  prg_bank_next;
    logic [1:0]  mirror_reg;
    logic [1:0]  mirror_next;
    logic [15:0] counter_reg;
    logic [15:0] counter_next;
    logic [15:0] counter_dec;
    logic        irq_en_reg;
    logic        irq_en_next;
    logic        irq_reg;
    logic        irq_next;
    logic [7:0]  prg_sel;
    logic [7:0]  pat_sel;
    logic [21:0] addr;

    assign counter_dec = counter_reg - 16'd1;

    // Next state for one request
    always_comb begin
        pat_bank_next = pat_bank_reg;
        prg_bank_next = prg_bank_reg;
        mirror_next   = mirror_reg;
        counter_next  = counter_reg;
        irq_en_next   = irq_en_reg;
        irq_next      = irq_reg;
        case (item.action)
            ACT_TICK: begin
                if (irq_en_reg) begin
                    counter_next = counter_dec;
                    if (counter_dec == 16'd0) begin
                        irq_next = 1'b1;
                    end
                end
            end
            ACT_WRITE: begin
                case (item.reg_index) inside
                    [REG_PAT_FIRST:REG_PAT_LAST]: begin
                        pat_bank_next[item.reg_index[2:0]] = item.write_value;
                    end
                    REG_PRG_BANK: prg_bank_next = item.write_value;
                    REG_MIRROR:   mirror_next = item.write_value[1:0];
                    REG_IRQ_CTRL: begin
                        irq_en_next = item.write_value[0];
                        irq_next    = item.write_value[0] && (counter_reg == 16'd0);
                    end
                    REG_CNT_LO:   counter_next = {counter_reg[15:8], item.write_value};
                    REG_CNT_HI:   counter_next = {item.write_value, counter_reg[7:0]};
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Translate program and pattern addresses
    always_comb begin
        prg_sel = map_bank(item.cpu_offset[14] ? FIXED_PRG_BANK : prg_bank_reg, cfg);
        pat_sel = map_bank(pat_bank_reg[item.ppu_offset[12:10]], cfg);
        case (item.action)
            ACT_PRG_XLATE: addr = {prg_sel, item.cpu_offset[13:0]};
            ACT_PAT_XLATE: addr = {4'd0, pat_sel, item.ppu_offset[9:0]};
            default:       addr = '0;
        endcase
    end

    assign result.irq_line    = irq_next;
    assign result.mapped_addr = addr;
    assign result.mirror_mode = mirror_next;

    // Commit state when the request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                pat_bank_reg[i] <= 8'(i);
            end
            prg_bank_reg <= '0;
            mirror_reg   <= '0;
            counter_reg  <= '0;
            irq_en_reg   <= 1'b0;
            irq_reg      <= 1'b0;
        end else if (fire) begin
            pat_bank_reg <= pat_bank_next;
            prg_bank_reg <= prg_bank_next;
            mirror_reg   <= mirror_next;
            counter_reg  <= counter_next;
            irq_en_reg   <= irq_en_next;
            irq_reg      <= irq_next;
        end
    end

endmodule

`default_nettype wire

>>> src/cartridge_bank_mapper_with_irq_counter.sv
// Top level of the cartridge bank mapper with interrupt counter.
// Each request (tick, register write, program or pattern translate) yields
// exactly one result. Requests flow through an input register and a result
// register with the mapper logic between them: a new request is taken every
// clock unless a full result register is stalled by m_ready, and a result is
// presented from the result register. Throughput is one request per cycle
// when the result side does not stall; state update and translation are done
// combinationally between the two registers. Configure bank_and_mask
// (0x0) and bank_or_bits (0x4) over APB only while no request is in flight.
`default_nettype none

module cartridge_bank_mapper_with_irq_counter
    import cbm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [3:0]  s_reg_index,
    input  wire logic [7:0]  s_write_value,
    input  wire logic [14:0] s_cpu_offset,
    input  wire logic [12:0] s_ppu_offset,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_irq_line,
    output logic [21:0]      m_mapped_addr,
    output logic [1:0]       m_mirror_mode
);

    bank_cfg_t cfg;
    item_t     s_item;
    item_t     held_item;
    logic      held_valid;
    logic      advance;
    result_t   result;
    result_t   out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    cbm_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_item.action      = action_t'(s_action);
    assign s_item.reg_index   = s_reg_index;
    assign s_item.write_value = s_write_value;
    assign s_item.cpu_offset  = s_cpu_offset;
    assign s_item.ppu_offset  = s_ppu_offset;

    cbm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (s_item),
        .held_valid (held_valid),
        .held_take  (advance),
        .held_item  (held_item)
    );

    // Move the held request into the result register when it has room
    assign advance = held_valid && (!out_valid_reg || m_ready);

    cbm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (held_item),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // Result register occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_irq_line    = out_reg.irq_line;
    assign m_mapped_addr = out_reg.mapped_addr;
    assign m_mirror_mode = out_reg.mirror_mode;

endmodule

`default_nettype wire

>>> src/cbm_checker.sv
// Port-level checks for the cartridge bank mapper, bound to the top level.
`default_nettype none

module cbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_irq_line,
    input wire logic [21:0] m_mapped_addr,
    input wire logic [1:0]  m_mirror_mode
);

    // No result is offered right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_irq_line)
            && $stable(m_mapped_addr) && $stable(m_mirror_mode))
        else $error("stalled result changed");

    // Requests back up only behind a stalled result
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request stalled without result backpressure");

    // With the pipeline drained, a taken result leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(s_valid && s_ready) && $past(s_ready && !s_valid)
            && $past(aresetn) |=> !m_valid)
        else $error("result appeared without a request");

endmodule

bind cartridge_bank_mapper_with_irq_counter cbm_checker u_cbm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_irq_line    (m_irq_line),
    .m_mapped_addr (m_mapped_addr),
    .m_mirror_mode (m_mirror_mode)
);

`default_nettype wire

>>> verif/cartridge_bank_mapper_with_irq_counter_test.sv
// Self-checking testbench for the cartridge bank mapper with interrupt counter.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq_counter_test
    import cbm_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 150;
    localparam int PHASE_COUNT = 7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [3:0]  s_reg_index = '0;
    logic [7:0]  s_write_value = '0;
    logic [14:0] s_cpu_offset = '0;
    logic [12:0] s_ppu_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_irq_line;
    logic [21:0] m_mapped_addr;
    logic [1:0]  m_mirror_mode;

    // Mapper state as the testbench predicts it
    logic [7:0]  chr_bank [8];
    logic [7:0]  prg_select;
    logic [1:0]  mirroring;
    logic [15:0] irq_count;
    logic        irq_armed;
    logic        irq_raised;
    bank_cfg_t   bank_cfg;

    result_t     pending_responses [$];
    result_t     want;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          gaps_enabled = 1'b1;

    cartridge_bank_mapper_with_irq_counter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_reg_index   (s_reg_index),
        .s_write_value (s_write_value),
        .s_cpu_offset  (s_cpu_offset),
        .s_ppu_offset  (s_ppu_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_irq_line    (m_irq_line),
        .m_mapped_addr (m_mapped_addr),
        .m_mirror_mode (m_mirror_mode)
    );

    always #10 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Mask a bank number, then force the configured bits on
    function automatic logic [7:0] apply_bank_cfg(input logic [7:0] bank);
        return (bank & bank_cfg.and_mask) | bank_cfg.or_bits;
    endfunction

    // Advance the predicted state by one request and return its response
    function automatic result_t compute_mapper_response(input item_t req);
        result_t res;
        logic [7:0] bank;
        res = '0;
        bank = '0;
        case (req.action)
            ACT_TICK: begin
                if (irq_armed) begin
                    irq_count = irq_count - 16'd1;
                    if (irq_count == 16'd0)
                        irq_raised = 1'b1;
                end
            end
            ACT_WRITE: begin
                case (req.reg_index)
                    REG_PRG_BANK: prg_select = req.write_value;
                    REG_MIRROR:   mirroring = req.write_value[1:0];
                    REG_IRQ_CTRL: begin
                        irq_armed = req.write_value[0];
                        irq_raised = irq_armed && (irq_count == 16'd0);
                    end
                    REG_CNT_LO:   irq_count[7:0] = req.write_value;
                    REG_CNT_HI:   irq_count[15:8] = req.write_value;
                    default: begin
                        if (req.reg_index <= REG_PAT_LAST)
                            chr_bank[req.reg_index[2:0]] = req.write_value;
                    end
                endcase
            end
            ACT_PRG_XLATE: begin
                bank = req.cpu_offset[14] ? FIXED_PRG_BANK : prg_select;
                res.mapped_addr = {apply_bank_cfg(bank), req.cpu_offset[13:0]};
            end
            default: begin
                bank = chr_bank[req.ppu_offset[12:10]];
                res.mapped_addr = {4'd0, apply_bank_cfg(bank), req.ppu_offset[9:0]};
            end
        endcase
        res.irq_line = irq_raised;
        res.mirror_mode = mirroring;
        return res;
    endfunction

    function automatic item_t make_request(input action_t act, input logic [3:0] idx,
                                           input logic [7:0] val, input logic [14:0] cpu,
                                           input logic [12:0] ppu);
        item_t r;
        r.action = act;
        r.reg_index = idx;
        r.write_value = val;
        r.cpu_offset = cpu;
        r.ppu_offset = ppu;
        return r;
    endfunction

    // Random request, biased so that the counter often reaches zero
    function automatic item_t random_request();
        item_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.action = ACT_TICK;
        else if (pick < 65)
            r.action = ACT_WRITE;
        else if (pick < 82)
            r.action = ACT_PRG_XLATE;
        else
            r.action = ACT_PAT_XLATE;
        r.reg_index = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 4)
            r.reg_index = REG_IRQ_CTRL + 4'($urandom_range(0, 2));
        r.write_value = 8'($urandom_range(0, 255));
        if (r.reg_index == REG_CNT_LO && $urandom_range(0, 9) < 6)
            r.write_value = 8'($urandom_range(0, 6));
        if (r.reg_index == REG_CNT_HI && $urandom_range(0, 3) != 0)
            r.write_value = 8'd0;
        r.cpu_offset = 15'($urandom_range(0, 32767));
        r.ppu_offset = 13'($urandom_range(0, 8191));
        return r;
    endfunction

    // Present one request, hold it until accepted, then record its response
    task automatic issue_request(input item_t req);
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= req.action;
        s_reg_index <= req.reg_index;
        s_write_value <= req.write_value;
        s_cpu_offset <= req.cpu_offset;
        s_ppu_offset <= req.ppu_offset;
        do @(posedge aclk); while (!s_ready);
        pending_responses.push_back(compute_mapper_response(req));
    endtask

    // Drop valid and wait for every response plus the pipeline depth
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write_cfg(input logic cfg_index, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {cfg_index, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (cfg_index == CFG_AND_MASK)
            bank_cfg.and_mask = value;
        else
            bank_cfg.or_bits = value;
    endtask

    // Reset banks, window edges and a disabled tick
    task automatic test_reset_defaults();
        issue_request(make_request(ACT_PAT_XLATE, 4'hF, 8'hFF, 15'h7FFF, 13'h0000));
        issue_request(make_request(ACT_PAT_XLATE, 4'h0, 8'h00, 15'h0000, 13'h1FFF));
        issue_request(make_request(ACT_PRG_XLATE, 4'hF, 8'hFF, 15'h0000, 13'h1FFF));
        issue_request(make_request(ACT_PRG_XLATE, 4'h0, 8'h00, 15'h7FFF, 13'h0000));
        issue_request(make_request(ACT_TICK, 4'hA, 8'h01, 15'h7FFF, 13'h1FFF));
    endtask

    // Bank, mirroring and unused registers at their extremes
    task automatic test_bank_writes();
        issue_request(make_request(ACT_WRITE, REG_PAT_FIRST, 8'hFF, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_PAT_LAST, 8'h00, 15'h7FFF, 13'h1FFF));
        issue_request(make_request(ACT_WRITE, REG_PRG_BANK, 8'hFF, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_MIRROR, 8'hFF, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, 4'd13, 8'hFF, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, 4'd15, 8'h5A, 15'h0, 13'h0));
        issue_request(make_request(ACT_PAT_XLATE, 4'h0, 8'h00, 15'h0, 13'h0000));
        issue_request(make_request(ACT_PAT_XLATE, 4'h0, 8'h00, 15'h0, 13'h1FFF));
        issue_request(make_request(ACT_PRG_XLATE, 4'h0, 8'h00, 15'h3FFF, 13'h0));
        issue_request(make_request(ACT_PRG_XLATE, 4'h0, 8'h00, 15'h4000, 13'h0));
    endtask

    // Countdown to zero, wrap, clear, and assert on enable with a zero count
    task automatic test_irq_counter();
        issue_request(make_request(ACT_WRITE, REG_CNT_LO, 8'h02, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_CNT_HI, 8'h00, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_IRQ_CTRL, 8'h01, 15'h0, 13'h0));
        repeat (3) issue_request(make_request(ACT_TICK, 4'h0, 8'h00, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_IRQ_CTRL, 8'h03, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_CNT_HI, 8'h00, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_CNT_LO, 8'h00, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_IRQ_CTRL, 8'hFF, 15'h0, 13'h0));
        issue_request(make_request(ACT_WRITE, REG_IRQ_CTRL, 8'hFE, 15'h0, 13'h0));
        issue_request(make_request(ACT_TICK, 4'h0, 8'h00, 15'h0, 13'h0));
    endtask

    // Random traffic under a series of bank settings, the last one without gaps
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_until_idle();
            case (phase)
                1: begin
                    apb_write_cfg(CFG_AND_MASK, 8'h00);
                    apb_write_cfg(CFG_OR_BITS, 8'hFF);
                end
                2: apb_write_cfg(CFG_OR_BITS, 8'h00);
                3: begin
                    apb_write_cfg(CFG_AND_MASK, 8'hFF);
                    apb_write_cfg(CFG_OR_BITS, 8'hFF);
                end
                4: begin
                    apb_write_cfg(CFG_AND_MASK, 8'h0F);
                    apb_write_cfg(CFG_OR_BITS, 8'hA0);
                end
                5: begin
                    apb_write_cfg(CFG_AND_MASK, 8'($urandom_range(0, 255)));
                    apb_write_cfg(CFG_OR_BITS, 8'($urandom_range(0, 255)));
                end
                6: begin
                    apb_write_cfg(CFG_AND_MASK, BANK_MASK_RESET);
                    apb_write_cfg(CFG_OR_BITS, BANK_OR_RESET);
                    gaps_enabled = 1'b0;
                end
                default: ;
            endcase
            repeat (PHASE_ITEMS) issue_request(random_request());
        end
    endtask

    // Drive result backpressure in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response with no request pending");
            end else begin
                want = pending_responses.pop_front();
                if (m_irq_line !== want.irq_line)
                    report_mismatch($sformatf("irq_line got %b want %b",
                                              m_irq_line, want.irq_line));
                if (m_mapped_addr !== want.mapped_addr)
                    report_mismatch($sformatf("mapped_addr got %h want %h",
                                              m_mapped_addr, want.mapped_addr));
                if (m_mirror_mode !== want.mirror_mode)
                    report_mismatch($sformatf("mirror_mode got %0d want %0d",
                                              m_mirror_mode, want.mirror_mode));
            end
        end
    end

    initial begin
        for (int i = 0; i < 8; i++)
            chr_bank[i] = 8'(i);
        prg_select = '0;
        mirroring = '0;
        irq_count = '0;
        irq_armed = 1'b0;
        irq_raised = 1'b0;
        bank_cfg.and_mask = BANK_MASK_RESET;
        bank_cfg.or_bits = BANK_OR_RESET;

        // Hold reset, then release it once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_bank_writes();
        test_irq_counter();
        test_random_traffic();

        wait_until_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
src/cbm_pkg.sv
src/cbm_apb_regs.sv
src/cbm_in_stage.sv
src/cbm_engine.sv
src/cartridge_bank_mapper_with_irq_counter.sv
src/cbm_checker.sv
verif/cartridge_bank_mapper_with_irq_counter_test.sv
